// ----- hdl/fcf_pkg.sv -----
// ----------------------------------------------------------------------------
// FIR convolution filter package
// Shared codes, widths and the control word that the sequencer passes to the
// multiply-accumulate unit.
// ----------------------------------------------------------------------------
package fcf_pkg;

   // Field widths fixed by the stream format.
   localparam int TAP_INDEX_BITS = 10;
   localparam int TAP_COUNT_BITS = 11;

   // Width of the running sum of products.
   localparam int ACC_BITS = 64;

   // Item kinds carried in req_tuser.
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_FILTER = 1'b1;

   // One step of the tap walk, issued together with the memory reads.
   typedef struct packed {
      logic valid;   // a tap read is issued in this cycle
      logic first;   // first tap of the sample, restarts the sum
      logic last;    // last tap of the sample
      logic live;    // the history entry was written since reset
   } mac_ctrl_type;

endpackage

// ----- hdl/fir_convolution_filter.sv -----
// ----------------------------------------------------------------------------
// FIR convolution filter
// Direct-form FIR with a loadable coefficient memory and a circular sample
// history, evaluated by one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// A load transaction (tuser 0) writes one coefficient; a load with a tap index
// at or above TAPS is dropped. A filter transaction (tuser 1) pushes the
// sample into the history and then raises rsp_tvalid with the filtered sample:
// the sequencer reads one coefficient and one history entry per cycle from the
// two memories, one pair per tap, and then come the multiply, the last
// accumulate, rounding, saturation, the hand-over and the output register.
// Only one item is worked on at a time, so a filter transaction is accepted
// only once the last one has reached the output register; a finished result
// sits in the output register and the next item can be accepted meanwhile.
// History entries not yet written since reset are masked by a fill count, so
// the block is ready right after reset with no clearing pass. tap_count is
// clamped to 1..TAPS and must be written only while the block is idle.
module fir_convolution_filter
   import fcf_pkg::*;
#(
   parameter int TAPS        = 1024,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   // tdata: tap_index [9:0], sample_value [SAMPLE_BITS+9:10], zero fill above
   input  logic [((TAP_INDEX_BITS+SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   // tuser: cmd [0]
   input  logic [0:0]                         req_tuser,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata: out_sample [SAMPLE_BITS-1:0], zero fill above
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]   rsp_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [TAP_COUNT_BITS-1:0]          csr_data,
   input  logic                               csr_valid,
   output logic                               csr_ready
);

   localparam int AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int CW    = $clog2(TAPS + 1);
   localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;

   localparam logic [AW-1:0] LAST_POS = AW'(TAPS - 1);
   localparam logic [CW-1:0] FULL     = CW'(TAPS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_WAIT,
      ST_OUT
   } state_type;

   state_type                       state_ff, state_in;
   logic [AW-1:0]                   wr_pos_ff, wr_pos_in;
   logic [AW-1:0]                   rd_pos_ff, rd_pos_in;
   logic [AW-1:0]                   step_ff, step_in;
   logic [CW-1:0]                   fill_ff, fill_in;
   logic [TAP_COUNT_BITS-1:0]       tap_count_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0]          rsp_data_ff, rsp_data_in;

   logic                            req_accept;
   logic                            req_cmd;
   logic [TAP_INDEX_BITS-1:0]       req_tap_index;
   logic signed [SAMPLE_BITS-1:0]   req_sample;
   logic [31:0]                     index_wide;
   logic [31:0]                     tap_count_wide;
   logic [31:0]                     tap_lim;
   logic [31:0]                     tap_lim_m1;
   logic [AW-1:0]                   last_step;
   logic                            step_last;

   logic                            coef_we;
   logic                            hist_we;
   logic                            rd_en;
   mac_ctrl_type                    mac_ctrl;
   logic signed [SAMPLE_BITS-1:0]   coef_q;
   logic signed [SAMPLE_BITS-1:0]   hist_q;
   logic                            mac_res_valid;
   logic signed [SAMPLE_BITS-1:0]   mac_res_sample;

   assign req_tap_index = req_tdata[TAP_INDEX_BITS-1:0];
   assign req_sample    = req_tdata[TAP_INDEX_BITS +: SAMPLE_BITS];
   assign req_cmd       = req_tuser[0];
   assign req_tready    = (state_ff == ST_IDLE);
   assign req_accept    = req_tvalid && req_tready;
   assign csr_ready     = 1'b1;

   assign index_wide     = 32'(req_tap_index);
   assign tap_count_wide = 32'(tap_count_ff);

   always_comb begin
      if (tap_count_wide == 32'd0) begin
         tap_lim = 32'd1;
      end else if (tap_count_wide > 32'(TAPS)) begin
         tap_lim = 32'(TAPS);
      end else begin
         tap_lim = tap_count_wide;
      end
   end

   assign tap_lim_m1 = tap_lim - 32'd1;
   assign last_step  = tap_lim_m1[AW-1:0];
   assign step_last  = (step_ff == last_step);

   always_comb begin
      state_in     = state_ff;
      wr_pos_in    = wr_pos_ff;
      rd_pos_in    = rd_pos_ff;
      step_in      = step_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      coef_we      = 1'b0;
      hist_we      = 1'b0;
      rd_en        = 1'b0;
      mac_ctrl     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_cmd == CMD_LOAD) begin
                  coef_we = (index_wide < 32'(TAPS));
               end else begin
                  hist_we   = 1'b1;
                  rd_pos_in = wr_pos_ff;
                  wr_pos_in = (wr_pos_ff == LAST_POS) ? '0 : wr_pos_ff + 1'b1;
                  fill_in   = (fill_ff == FULL) ? fill_ff : fill_ff + 1'b1;
                  step_in   = '0;
                  state_in  = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            // Walk the taps: coefficient m against the sample m items back.
            rd_en          = 1'b1;
            mac_ctrl.valid = 1'b1;
            mac_ctrl.first = (step_ff == '0);
            mac_ctrl.last  = step_last;
            mac_ctrl.live  = (32'(step_ff) < 32'(fill_ff));
            step_in        = step_ff + 1'b1;
            rd_pos_in      = (rd_pos_ff == '0) ? LAST_POS : rd_pos_ff - 1'b1;
            if (step_last) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (mac_res_valid) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = mac_res_sample;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_pos_ff    <= '0;
         fill_ff      <= '0;
         tap_count_ff <= TAP_COUNT_BITS'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_pos_ff    <= wr_pos_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            tap_count_ff <= csr_data;
         end
      end
      rd_pos_ff   <= rd_pos_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_W'(rsp_data_ff);

   fcf_ram #(
      .DEPTH (TAPS),
      .AW    (AW),
      .WIDTH (SAMPLE_BITS)
   ) u_coef_ram (
      .clock (clock),
      .we    (coef_we),
      .waddr (index_wide[AW-1:0]),
      .wdata (req_sample),
      .re    (rd_en),
      .raddr (step_ff),
      .rdata (coef_q)
   );

   fcf_ram #(
      .DEPTH (TAPS),
      .AW    (AW),
      .WIDTH (SAMPLE_BITS)
   ) u_hist_ram (
      .clock (clock),
      .we    (hist_we),
      .waddr (wr_pos_ff),
      .wdata (req_sample),
      .re    (rd_en),
      .raddr (rd_pos_ff),
      .rdata (hist_q)
   );

   fcf_mac #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (mac_ctrl),
      .coef_q     (coef_q),
      .hist_q     (hist_q),
      .res_valid  (mac_res_valid),
      .res_sample (mac_res_sample)
   );

`ifndef SYNTH
   // A finished sum only ever arrives while the sequencer waits for it.
   a_result_in_wait: assert property (@(posedge clock) disable iff (reset)
      mac_res_valid |-> state_ff == ST_WAIT)
      else $error("MAC result arrived outside the wait state");

   // The tap walk ends exactly on the last tap.
   a_walk_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && step_last) |=> state_ff == ST_WAIT)
      else $error("tap walk did not stop after the last tap");

   // Until the history is full, the write pointer equals the fill count.
   a_fill_tracks_pos: assert property (@(posedge clock) disable iff (reset)
      (fill_ff != FULL) |-> 32'(wr_pos_ff) == 32'(fill_ff))
      else $error("history fill count and write pointer disagree");

   // A pending result is never overwritten by the next one.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_valid_ff && !rsp_tready) |=> state_ff == ST_OUT)
      else $error("result register overwritten while still pending");
`endif

endmodule

// ----- hdl/fcf_ram.sv -----
// ----------------------------------------------------------------------------
// FIR convolution filter RAM
// Simple dual-port synchronous memory: one write port, one read port with a
// registered read data output.
// ----------------------------------------------------------------------------
module fcf_ram #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int WIDTH = 24
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- hdl/fcf_mac.sv -----
// ----------------------------------------------------------------------------
// FIR convolution filter multiply-accumulate unit
// Registered multiply, 64-bit saturating accumulate, then round half up and
// saturate the sum back to a Q1.(SAMPLE_BITS-1) sample.
// ----------------------------------------------------------------------------
module fcf_mac
   import fcf_pkg::*;
#(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mac_ctrl_type                  ctrl,
   input  logic signed [SAMPLE_BITS-1:0] coef_q,
   input  logic signed [SAMPLE_BITS-1:0] hist_q,
   output logic                          res_valid,
   output logic signed [SAMPLE_BITS-1:0] res_sample
);

   localparam int FRAC = SAMPLE_BITS - 1;
   localparam int PW   = 2 * SAMPLE_BITS;

   localparam logic [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
   localparam logic [ACC_BITS-1:0] HALF    = ACC_BITS'(1) << (FRAC - 1);
   localparam logic signed [ACC_BITS-1:0] OUT_MAX = (ACC_BITS'(1) << FRAC) - ACC_BITS'(1);
   localparam logic signed [ACC_BITS-1:0] OUT_MIN = ~OUT_MAX;

   mac_ctrl_type                   ctrl_d_ff;
   mac_ctrl_type                   ctrl_p_ff;
   logic signed [PW-1:0]           prod_ff;
   logic signed [PW-1:0]           prod_in;
   logic signed [ACC_BITS-1:0]     prod_ext;
   logic signed [ACC_BITS-1:0]     acc_ff;
   logic signed [ACC_BITS-1:0]     acc_in;
   logic        [ACC_BITS:0]       acc_sum;
   logic                           acc_done_ff;
   logic signed [ACC_BITS-1:0]     rnd_ff;
   logic signed [ACC_BITS-1:0]     rnd_in;
   logic        [ACC_BITS:0]       rnd_sum;
   logic                           rnd_valid_ff;
   logic signed [ACC_BITS-1:0]     shifted;
   logic signed [SAMPLE_BITS-1:0]  res_ff;
   logic signed [SAMPLE_BITS-1:0]  res_in;
   logic                           res_valid_ff;

   // Taps whose history entry was never written contribute zero.
   always_comb begin
      if (ctrl_d_ff.live) begin
         prod_in = coef_q * hist_q;
      end else begin
         prod_in = '0;
      end
   end

   assign prod_ext = ACC_BITS'(prod_ff);
   assign acc_sum  = {acc_ff[ACC_BITS-1], acc_ff} + {prod_ext[ACC_BITS-1], prod_ext};

   always_comb begin
      if (ctrl_p_ff.first) begin
         acc_in = prod_ext;
      end else if (acc_sum[ACC_BITS] != acc_sum[ACC_BITS-1]) begin
         acc_in = acc_sum[ACC_BITS] ? ACC_MIN : ACC_MAX;
      end else begin
         acc_in = acc_sum[ACC_BITS-1:0];
      end
   end

   // The rounding constant is positive, so only the upper bound can be hit.
   assign rnd_sum = {acc_ff[ACC_BITS-1], acc_ff} + {1'b0, HALF};

   always_comb begin
      if (rnd_sum[ACC_BITS] != rnd_sum[ACC_BITS-1]) begin
         rnd_in = ACC_MAX;
      end else begin
         rnd_in = rnd_sum[ACC_BITS-1:0];
      end
   end

   // An arithmetic shift floors, which together with the added half rounds up.
   assign shifted = rnd_ff >>> FRAC;

   always_comb begin
      if (shifted > OUT_MAX) begin
         res_in = OUT_MAX[SAMPLE_BITS-1:0];
      end else if (shifted < OUT_MIN) begin
         res_in = OUT_MIN[SAMPLE_BITS-1:0];
      end else begin
         res_in = shifted[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_d_ff    <= '0;
         ctrl_p_ff    <= '0;
         acc_done_ff  <= 1'b0;
         rnd_valid_ff <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         ctrl_d_ff    <= ctrl;
         ctrl_p_ff    <= ctrl_d_ff;
         acc_done_ff  <= ctrl_p_ff.valid && ctrl_p_ff.last;
         rnd_valid_ff <= acc_done_ff;
         res_valid_ff <= rnd_valid_ff;
      end
      prod_ff <= prod_in;
      if (ctrl_p_ff.valid) begin
         acc_ff <= acc_in;
      end
      if (acc_done_ff) begin
         rnd_ff <= rnd_in;
      end
      if (rnd_valid_ff) begin
         res_ff <= res_in;
      end
   end

   assign res_valid  = res_valid_ff;
   assign res_sample = res_ff;

endmodule
